// ===== sv/mtev_pkg.sv =====
// Package for the MIDI track event validator: beat structs, error and
// operation codes, size constants and status byte helpers.
// No dependencies.
`default_nettype none

package mtev_pkg;

    localparam int MAX_VLQ_BYTES = 4;
    localparam int VLQ_CNT_W     = $clog2(MAX_VLQ_BYTES + 1);
    localparam int LEN_W         = 28;
    localparam int SIZE_W        = 29;

    localparam logic [1:0] OP_CHANNEL = 2'd0;
    localparam logic [1:0] OP_META    = 2'd1;
    localparam logic [1:0] OP_SYSEX   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [7:0] STATUS_META     = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX    = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX_ESC = 8'hF7;

    localparam logic [3:0] NYB_PROGRAM  = 4'hC;
    localparam logic [3:0] NYB_PRESSURE = 4'hD;
    localparam logic [3:0] NYB_SYSTEM   = 4'hF;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_NO_DATA     = 3'd1,
        ERR_BAD_STATUS  = 3'd2,
        ERR_CHAN_SHORT  = 3'd3,
        ERR_BAD_DATA    = 3'd4,
        ERR_HDR_SHORT   = 3'd5,
        ERR_BAD_VLQ     = 3'd6,
        ERR_PAY_SHORT   = 3'd7
    } t_err;

    typedef struct packed {
        logic [1:0] operation;
        logic       start_req;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       empty_buffer;
        logic [7:0] carried_status;
    } t_in_beat;

    typedef struct packed {
        t_err              error_code;
        logic [SIZE_W-1:0] event_size;
        logic [3:0]        status_upper;
        logic [3:0]        channel;
        logic [7:0]        first_data;
        logic [7:0]        second_data;
        logic [LEN_W-1:0]  payload_length;
    } t_out_beat;

    // Channel voice status: top bit set, not a system byte.
    function automatic logic is_chan_status(input logic [7:0] s);
        return s[7] && (s[7:4] != NYB_SYSTEM);
    endfunction

    // Program change and channel pressure carry one data byte, the rest two.
    function automatic logic chan_two_data(input logic [7:0] s);
        return !((s[7:4] == NYB_PROGRAM) || (s[7:4] == NYB_PRESSURE));
    endfunction

endpackage

`default_nettype wire

// ===== sv/midi_track_event_validator.sv =====
// Top level of the MIDI track event validator: input register, event engine
// and result register. Depends on mtev_pkg and mtev_engine.
//
// Usage: feed one event buffer per event, a byte per input beat, after the
// delta time has been stripped. The beat that carries start_req also carries
// the operation (channel, meta or sysex) and the running status byte in force.
// last_byte marks the final byte available; empty_buffer on a start beat
// means the buffer holds nothing.
// Each event yields exactly one result beat, as soon as its verdict is known;
// bytes that arrive after the verdict are dropped until the next start, and a
// start in mid-event abandons the unfinished one without a result.
// A beat accepted into the input register is checked by the engine while it
// is held there; its result, if any, is loaded into the result register,
// which drives o_out_valid. Throughput: one input beat per cycle unless stalled,
// since each byte updates the event state in one pass of short logic.
// Stall: while the result register holds a beat that the receiver stalls,
// the input register keeps its beat and o_in_stall rises; a result register
// that drains frees both stages in the same cycle.
// Reset (i_rst_n low, synchronous): both stages empty, engine idle.
`default_nettype none

module midi_track_event_validator
    import mtev_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_beat
);

    logic       r_in_valid;
    t_in_beat   r_in;
    logic       r_out_valid;
    t_out_beat  r_out;

    logic       w_out_free;
    logic       w_advance;
    logic       w_emit;
    t_out_beat  w_result;

    // The result register can take a beat when empty or draining this cycle.
    assign w_out_free = !r_out_valid || !i_out_stall;
    // Process the held input beat only when its possible result has a place.
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Capture the input beat; hold it while stalled.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_beat;
        end
    end

    mtev_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(w_advance),
        .i_beat   (r_in),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_advance && w_emit;
        end
    end

    // Load a verdict; hold the beat while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (w_advance && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_in_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && o_in_stall |=> r_in_valid)
        else $error("input beat lost while result register blocked");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_verdict_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance && w_emit |=> r_out_valid)
        else $error("verdict did not reach the result register");

endmodule

`default_nettype wire

// ===== sv/mtev_engine.sv =====
// Event state and per-byte verdict logic for the MIDI track event validator.
// Depends on mtev_pkg.
`default_nettype none

module mtev_engine
    import mtev_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_advance,
    input  wire t_in_beat  i_beat,
    output logic           o_emit,
    output t_out_beat      o_result
);

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_CHAN = 5'b00010,
        PH_HDR  = 5'b00100,
        PH_VLQ  = 5'b01000,
        PH_PAY  = 5'b10000
    } t_phase;

    t_phase                r_phase,   n_phase;
    logic [7:0]            r_status,  n_status;
    logic [7:0]            r_held,    n_held;
    logic                  r_want,    n_want;
    t_err                  r_pending, n_pending;
    logic [LEN_W-1:0]      r_acc,     n_acc;
    logic [LEN_W-1:0]      r_remain,  n_remain;
    logic [VLQ_CNT_W-1:0]  r_vlq,     n_vlq;
    logic [SIZE_W-1:0]     r_count,   n_count;

    logic [7:0]            w_b;
    logic [7:0]            w_sel_status;
    logic [LEN_W-1:0]      w_acc_shift;
    logic [VLQ_CNT_W-1:0]  w_vlq_inc;
    logic [SIZE_W-1:0]     w_count_inc;
    logic                  w_hdr_ok;

    assign w_b          = i_beat.data_byte;
    assign w_sel_status = w_b[7] ? w_b :
                          (is_chan_status(i_beat.carried_status) ?
                           i_beat.carried_status : 8'h00);
    assign w_acc_shift  = {r_acc[LEN_W-8:0], w_b[6:0]};
    assign w_vlq_inc    = r_vlq + 1'b1;
    assign w_count_inc  = r_count + 1'b1;
    assign w_hdr_ok     = (i_beat.operation == OP_META) ? (w_b == STATUS_META) :
                          ((w_b == STATUS_SYSEX) || (w_b == STATUS_SYSEX_ESC));

    always_comb begin
        n_phase   = r_phase;
        n_status  = r_status;
        n_held    = r_held;
        n_want    = r_want;
        n_pending = r_pending;
        n_acc     = r_acc;
        n_remain  = r_remain;
        n_vlq     = r_vlq;
        n_count   = r_count;
        o_emit    = 1'b0;
        o_result  = '0;

        if (i_beat.start_req) begin
            // a new buffer drops whatever event was in progress
            n_phase   = PH_IDLE;
            n_status  = 8'h00;
            n_held    = 8'h00;
            n_want    = 1'b0;
            n_pending = ERR_OK;
            n_acc     = '0;
            n_remain  = '0;
            n_vlq     = '0;
            n_count   = '0;
            if (i_beat.operation == OP_NONE) begin
                o_emit              = 1'b1;
                o_result.error_code = ERR_BAD_STATUS;
            end else if (i_beat.empty_buffer) begin
                o_emit              = 1'b1;
                o_result.error_code = (i_beat.operation == OP_CHANNEL) ?
                                      ERR_NO_DATA : ERR_HDR_SHORT;
            end else if (i_beat.operation == OP_CHANNEL) begin
                if (!is_chan_status(w_sel_status)) begin
                    o_emit              = 1'b1;
                    o_result.error_code = ERR_BAD_STATUS;
                end else begin
                    n_status = w_sel_status;
                    n_count  = SIZE_W'(1);
                    if (w_b[7]) begin
                        n_want = 1'b1;
                    end else begin
                        n_held = w_b;
                    end
                    if (!w_b[7] && !chan_two_data(w_sel_status)) begin
                        o_emit                 = 1'b1;
                        o_result.error_code    = ERR_OK;
                        o_result.event_size    = SIZE_W'(1);
                        o_result.status_upper  = w_sel_status[7:4];
                        o_result.channel       = w_sel_status[3:0];
                        o_result.first_data    = w_b;
                    end else if (i_beat.last_byte) begin
                        o_emit                 = 1'b1;
                        o_result.error_code    = ERR_CHAN_SHORT;
                        o_result.status_upper  = w_sel_status[7:4];
                        o_result.channel       = w_sel_status[3:0];
                    end else begin
                        n_phase = PH_CHAN;
                    end
                end
            end else begin
                n_status  = w_b;
                n_pending = w_hdr_ok ? ERR_OK : ERR_BAD_STATUS;
                n_count   = SIZE_W'(1);
                if (i_beat.last_byte) begin
                    o_emit              = 1'b1;
                    o_result.error_code = ERR_HDR_SHORT;
                end else begin
                    n_phase = (i_beat.operation == OP_META) ? PH_HDR : PH_VLQ;
                end
            end
        end else if (!i_beat.empty_buffer) begin
            case (r_phase)
                PH_CHAN: begin
                    n_count                = w_count_inc;
                    o_result.status_upper  = r_status[7:4];
                    o_result.channel       = r_status[3:0];
                    if (r_want) begin
                        n_held = w_b;
                        n_want = 1'b0;
                        if (!chan_two_data(r_status)) begin
                            o_emit              = 1'b1;
                            o_result.error_code = w_b[7] ? ERR_BAD_DATA : ERR_OK;
                            o_result.event_size = w_b[7] ? '0 : w_count_inc;
                            o_result.first_data = w_b;
                        end else begin
                            if (w_b[7]) begin
                                n_pending = ERR_BAD_DATA;
                            end
                            if (i_beat.last_byte) begin
                                o_emit              = 1'b1;
                                o_result.error_code = ERR_CHAN_SHORT;
                            end
                        end
                    end else begin
                        o_emit              = 1'b1;
                        o_result.first_data = r_held;
                        if (r_pending != ERR_OK) begin
                            o_result.error_code = ERR_BAD_DATA;
                        end else if (w_b[7]) begin
                            o_result.error_code  = ERR_BAD_DATA;
                            o_result.second_data = w_b;
                        end else begin
                            o_result.error_code  = ERR_OK;
                            o_result.event_size  = w_count_inc;
                            o_result.second_data = w_b;
                        end
                    end
                end
                PH_HDR: begin
                    n_count = w_count_inc;
                    if (i_beat.last_byte) begin
                        o_emit              = 1'b1;
                        o_result.error_code = ERR_HDR_SHORT;
                    end else begin
                        n_phase = PH_VLQ;
                    end
                end
                PH_VLQ: begin
                    if ((r_vlq == '0) && (r_pending != ERR_OK)) begin
                        o_emit              = 1'b1;
                        o_result.error_code = r_pending;
                    end else begin
                        n_acc    = w_acc_shift;
                        n_vlq    = w_vlq_inc;
                        n_count  = w_count_inc;
                        n_remain = w_acc_shift;
                        if (w_b[7]) begin
                            if ((w_vlq_inc >= VLQ_CNT_W'(MAX_VLQ_BYTES)) ||
                                i_beat.last_byte) begin
                                o_emit              = 1'b1;
                                o_result.error_code = ERR_BAD_VLQ;
                            end
                        end else if (w_acc_shift == '0) begin
                            o_emit              = 1'b1;
                            o_result.error_code = ERR_OK;
                            o_result.event_size = w_count_inc;
                        end else if (i_beat.last_byte) begin
                            o_emit                  = 1'b1;
                            o_result.error_code     = ERR_PAY_SHORT;
                            o_result.payload_length = w_acc_shift;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    n_count  = w_count_inc;
                    n_remain = r_remain - 1'b1;
                    if (r_remain == LEN_W'(1)) begin
                        o_emit                  = 1'b1;
                        o_result.error_code     = ERR_OK;
                        o_result.event_size     = w_count_inc;
                        o_result.payload_length = r_acc;
                    end else if (i_beat.last_byte) begin
                        o_emit                  = 1'b1;
                        o_result.error_code     = ERR_PAY_SHORT;
                        o_result.payload_length = r_acc;
                    end
                end
                default: begin
                    // idle: stray bytes are dropped
                end
            endcase
        end

        if (o_emit) begin
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_status  <= 8'h00;
            r_held    <= 8'h00;
            r_want    <= 1'b0;
            r_pending <= ERR_OK;
            r_acc     <= '0;
            r_remain  <= '0;
            r_vlq     <= '0;
            r_count   <= '0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_status  <= n_status;
            r_held    <= n_held;
            r_want    <= n_want;
            r_pending <= n_pending;
            r_acc     <= n_acc;
            r_remain  <= n_remain;
            r_vlq     <= n_vlq;
            r_count   <= n_count;
        end
    end

    a_err_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_emit && (o_result.error_code != ERR_OK)
        |-> o_result.event_size == '0)
        else $error("error verdict carries a nonzero event size");

    a_pay_remain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_remain != '0))
        else $error("payload phase with nothing left to count");

    a_vlq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VLQ) |-> (r_vlq < VLQ_CNT_W'(MAX_VLQ_BYTES)))
        else $error("length field ran past its byte limit");

endmodule

`default_nettype wire

// ===== tb/midi_track_event_validator_tb.sv =====
// Testbench for midi_track_event_validator: feeds channel, meta and sysex event
// buffers a byte per beat, predicts each verdict in-bench and checks every result beat.
// Depends on mtev_pkg and the validator RTL.
module midi_track_event_validator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mtev_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RANDOM_BEATS = 1050;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int IN_W         = $bits(t_in_beat);

    // Event engine phases as the predictor sees them.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CHAN,
        PH_HDR,
        PH_VLQ,
        PH_PAY
    } t_phase;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      out_stall = 1'b0;
    logic      in_stall;
    logic      out_valid;
    t_out_beat out_beat;

    // Predictor state: one event in flight, cleared on every start beat.
    t_phase            evt_phase     = PH_IDLE;
    logic [1:0]        evt_kind      = '0;
    logic [7:0]        evt_status    = '0;
    logic [7:0]        evt_running   = '0;
    logic [7:0]        evt_first     = '0;
    logic [1:0]        evt_needed    = '0;
    logic [LEN_W-1:0]  evt_len       = '0;
    logic [2:0]        evt_vlq_count = '0;
    logic [SIZE_W-1:0] evt_count     = '0;
    t_err              evt_pending   = ERR_OK;

    // Verdict raised by the beat just judged, and the verdicts still owed by the block.
    bit          verdict_ready;
    t_out_beat   verdict_beat;
    t_out_beat   pending_verdicts[$];
    t_out_beat   oldest_verdict;
    logic [7:0]  buffer_bytes[$];
    int          mismatches = 0;
    int          beats_sent = 0;
    bit          quiet      = 1'b0;

    midi_track_event_validator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Verdict predictor
    // ------------------------------------------------------------------

    // A channel voice status: top bit set and not a system byte.
    function automatic bit voice_status(logic [7:0] s);
        return s[7] && (s[7:4] != NYB_SYSTEM);
    endfunction

    // Program change and channel pressure carry one data byte, all others two.
    function automatic logic [1:0] data_bytes_for(logic [7:0] s);
        return (s[7:4] == NYB_PROGRAM || s[7:4] == NYB_PRESSURE) ? 2'd1 : 2'd2;
    endfunction

    // Meta header is status plus type before the length; sysex is status alone.
    function automatic int header_bytes();
        return (evt_kind == OP_META) ? 2 : 1;
    endfunction

    // Record the verdict and drop back to idle; later bytes wait for a start.
    task automatic issue(t_err err, logic [SIZE_W-1:0] size, bit chan, logic [7:0] d1,
                         logic [7:0] d2, logic [LEN_W-1:0] plen);
        verdict_beat.error_code     = err;
        verdict_beat.event_size     = size;
        verdict_beat.status_upper   = chan ? evt_status[7:4] : 4'h0;
        verdict_beat.channel        = chan ? evt_status[3:0] : 4'h0;
        verdict_beat.first_data     = d1;
        verdict_beat.second_data    = d2;
        verdict_beat.payload_length = plen;
        verdict_ready = 1'b1;
        evt_phase     = PH_IDLE;
    endtask

    // First byte of a channel event: either an explicit status or a data byte
    // under running status.
    task automatic channel_start(logic [7:0] b, logic last);
        logic [7:0] s;
        logic [1:0] n;
        s = b[7] ? b : (voice_status(evt_running) ? evt_running : 8'h00);
        if (!voice_status(s)) begin
            issue(ERR_BAD_STATUS, '0, 1'b0, '0, '0, '0);
            return;
        end
        evt_status  = s;
        n           = data_bytes_for(s);
        evt_count   = SIZE_W'(1);
        evt_pending = ERR_OK;
        if (b[7]) begin
            evt_needed = n;
        end else begin
            evt_first  = b;
            evt_needed = n - 2'd1;
            if (evt_needed == 2'd0) begin
                issue(ERR_OK, evt_count, 1'b1, b, '0, '0);
                return;
            end
        end
        if (last) begin
            issue(ERR_CHAN_SHORT, '0, 1'b1, '0, '0, '0);
            return;
        end
        evt_phase = PH_CHAN;
    endtask

    // Data bytes of a channel event. A bad first byte of a two-byte event is
    // held back: running out of buffer still outranks it.
    task automatic channel_data(logic [7:0] b, logic last);
        logic [1:0] n;
        n = data_bytes_for(evt_status);
        evt_count++;
        if (evt_needed == n) begin
            evt_first = b;
            if (n == 2'd1) begin
                if (b[7])
                    issue(ERR_BAD_DATA, '0, 1'b1, b, '0, '0);
                else
                    issue(ERR_OK, evt_count, 1'b1, b, '0, '0);
                return;
            end
            if (b[7])
                evt_pending = ERR_BAD_DATA;
            evt_needed = 2'd1;
            if (last)
                issue(ERR_CHAN_SHORT, '0, 1'b1, '0, '0, '0);
        end else if (evt_pending != ERR_OK) begin
            issue(ERR_BAD_DATA, '0, 1'b1, evt_first, '0, '0);
        end else if (b[7]) begin
            issue(ERR_BAD_DATA, '0, 1'b1, evt_first, b, '0);
        end else begin
            issue(ERR_OK, evt_count, 1'b1, evt_first, b, '0);
        end
    endtask

    // One byte of the length field. A bad header status surfaces only here,
    // once the header is known to be complete.
    task automatic length_byte(logic [7:0] b, logic last);
        if (evt_vlq_count == 3'd0 && evt_pending != ERR_OK) begin
            issue(evt_pending, '0, 1'b0, '0, '0, '0);
            return;
        end
        evt_len = {evt_len[LEN_W-8:0], b[6:0]};
        evt_vlq_count++;
        evt_count++;
        if (b[7]) begin
            if (int'(evt_vlq_count) >= MAX_VLQ_BYTES || last)
                issue(ERR_BAD_VLQ, '0, 1'b0, '0, '0, '0);
        end else if (evt_len == '0) begin
            issue(ERR_OK, evt_count, 1'b0, '0, '0, '0);
        end else if (last) begin
            issue(ERR_PAY_SHORT, '0, 1'b0, '0, '0, evt_len);
        end else begin
            evt_phase = PH_PAY;
        end
    endtask

    // Advance the predictor by one accepted beat.
    task automatic judge_beat(t_in_beat b);
        verdict_ready = 1'b0;
        verdict_beat  = '0;
        if (b.start_req) begin
            // A start always abandons whatever was in flight.
            evt_kind      = b.operation;
            evt_running   = b.carried_status;
            evt_status    = '0;
            evt_first     = '0;
            evt_needed    = '0;
            evt_len       = '0;
            evt_vlq_count = '0;
            evt_count     = '0;
            evt_pending   = ERR_OK;
            evt_phase     = PH_IDLE;
            if (b.operation == OP_NONE) begin
                issue(ERR_BAD_STATUS, '0, 1'b0, '0, '0, '0);
            end else if (b.empty_buffer) begin
                issue((b.operation == OP_CHANNEL) ? ERR_NO_DATA : ERR_HDR_SHORT,
                      '0, 1'b0, '0, '0, '0);
            end else if (b.operation == OP_CHANNEL) begin
                channel_start(b.data_byte, b.last_byte);
            end else begin
                evt_status = b.data_byte;
                if (b.operation == OP_META)
                    evt_pending = (b.data_byte == STATUS_META) ? ERR_OK : ERR_BAD_STATUS;
                else
                    evt_pending = (b.data_byte == STATUS_SYSEX ||
                                   b.data_byte == STATUS_SYSEX_ESC) ? ERR_OK : ERR_BAD_STATUS;
                evt_count = SIZE_W'(1);
                if (b.last_byte)
                    issue(ERR_HDR_SHORT, '0, 1'b0, '0, '0, '0);
                else
                    evt_phase = (header_bytes() > 1) ? PH_HDR : PH_VLQ;
            end
        end else if (!b.empty_buffer) begin
            case (evt_phase)
                PH_CHAN: channel_data(b.data_byte, b.last_byte);
                PH_HDR: begin
                    evt_count++;
                    if (b.last_byte)
                        issue(ERR_HDR_SHORT, '0, 1'b0, '0, '0, '0);
                    else
                        evt_phase = PH_VLQ;
                end
                PH_VLQ: length_byte(b.data_byte, b.last_byte);
                PH_PAY: begin
                    evt_count++;
                    if (evt_count == SIZE_W'(header_bytes()) + SIZE_W'(evt_vlq_count) +
                                     SIZE_W'(evt_len))
                        issue(ERR_OK, evt_count, 1'b0, '0, '0, evt_len);
                    else if (b.last_byte)
                        issue(ERR_PAY_SHORT, '0, 1'b0, '0, '0, evt_len);
                end
                default: ;
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Idle length: mostly none, sometimes short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(24, 4);
    endfunction

    function automatic t_in_beat noise_beat();
        logic [IN_W-1:0] raw;
        raw = IN_W'($urandom);
        return raw;
    endfunction

    // Offer one beat, hold it until accepted, then judge it. Valid stays high
    // on return unless a gap follows, so back-to-back beats never drop it.
    task automatic send_beat(t_in_beat b);
        int g;
        in_beat  <= b;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (in_stall);
        judge_beat(b);
        if (verdict_ready)
            pending_verdicts.push_back(verdict_beat);
        g = quiet ? 0 : pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_fields(logic [1:0] op, logic start, logic [7:0] data, logic last,
                               logic empty, logic [7:0] running);
        t_in_beat b;
        b.operation      = op;
        b.start_req      = start;
        b.data_byte      = data;
        b.last_byte      = last;
        b.empty_buffer   = empty;
        b.carried_status = running;
        send_beat(b);
    endtask

    // Send buffer_bytes as one event buffer, now and then slipping in an
    // empty non-start beat that the block must pass over.
    task automatic send_buffer(logic [1:0] op, logic [7:0] running, bit mark_last);
        t_in_beat b;
        foreach (buffer_bytes[i]) begin
            if (i > 0 && $urandom_range(24) == 0) begin
                b              = noise_beat();
                b.start_req    = 1'b0;
                b.empty_buffer = 1'b1;
                send_beat(b);
            end
            b.operation      = (i == 0) ? op : 2'($urandom);
            b.start_req      = (i == 0);
            b.data_byte      = buffer_bytes[i];
            b.last_byte      = mark_last && (i == buffer_bytes.size() - 1);
            b.empty_buffer   = 1'b0;
            b.carried_status = (i == 0) ? running : 8'($urandom);
            send_beat(b);
            beats_sent++;
        end
    endtask

    // Append a length field, shortest form, occasionally with a padding lead.
    task automatic push_length(logic [LEN_W-1:0] value);
        int groups;
        groups = (value >= 28'h200000) ? 4 : (value >= 28'h4000) ? 3 :
                 (value >= 28'h80) ? 2 : 1;
        if (groups < MAX_VLQ_BYTES && $urandom_range(9) == 0)
            groups++;
        for (int i = groups - 1; i >= 0; i--)
            buffer_bytes.push_back({i != 0, 7'(value >> (7 * i))});
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: free stretches broken by stalls of random length
    // ------------------------------------------------------------------
    initial begin : receiver_stalls
        forever begin
            @(posedge i_clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(6)) @(posedge i_clk);
            if (!quiet && $urandom_range(3) != 0) begin
                @(posedge i_clk);
                out_stall <= 1'b1;
                repeat (pick_gap()) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest verdict
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t ns: result beat expected none actual %p", $time, out_beat);
                mismatches++;
            end else begin
                oldest_verdict = pending_verdicts.pop_front();
                compare_field("error_code", 32'(oldest_verdict.error_code),
                              32'(out_beat.error_code));
                compare_field("event_size", 32'(oldest_verdict.event_size),
                              32'(out_beat.event_size));
                compare_field("status_upper", 32'(oldest_verdict.status_upper),
                              32'(out_beat.status_upper));
                compare_field("channel", 32'(oldest_verdict.channel), 32'(out_beat.channel));
                compare_field("first_data", 32'(oldest_verdict.first_data),
                              32'(out_beat.first_data));
                compare_field("second_data", 32'(oldest_verdict.second_data),
                              32'(out_beat.second_data));
                compare_field("payload_length", 32'(oldest_verdict.payload_length),
                              32'(out_beat.payload_length));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Stray bytes, empty buffers and the unused operation code.
    task automatic test_stray_and_empty();
        send_fields(OP_CHANNEL, 1'b0, 8'h55, 1'b0, 1'b0, 8'h00);  // idle byte, dropped
        send_fields(OP_CHANNEL, 1'b1, 8'h00, 1'b0, 1'b1, 8'h00);  // empty channel buffer
        send_fields(OP_META,    1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF);  // empty, no start
        send_fields(OP_META,    1'b1, 8'hFF, 1'b0, 1'b1, 8'h00);  // empty meta buffer
        send_fields(OP_NONE,    1'b1, 8'h90, 1'b0, 1'b0, 8'h90);  // unused operation
        send_fields(OP_SYSEX,   1'b0, 8'h12, 1'b1, 1'b0, 8'h00);  // past the verdict
    endtask

    // Channel events: explicit and running status, short buffers, bad bytes.
    task automatic test_channel_events();
        // Start mid-event: the unfinished note-on is abandoned without a result.
        send_fields(OP_CHANNEL, 1'b1, 8'h9F, 1'b0, 1'b0, 8'h00);
        send_fields(OP_CHANNEL, 1'b1, 8'h00, 1'b0, 1'b0, 8'hC3);  // program change, running
        // Bad first data byte and the buffer ends: short buffer wins.
        send_fields(OP_CHANNEL, 1'b1, 8'hE0, 1'b0, 1'b0, 8'h00);
        send_fields(OP_CHANNEL, 1'b0, 8'hFF, 1'b1, 1'b0, 8'h00);
        // Data byte first with a system byte as running status.
        send_fields(OP_CHANNEL, 1'b1, 8'h7F, 1'b0, 1'b0, 8'hF0);
        send_fields(OP_CHANNEL, 1'b1, 8'h80, 1'b0, 1'b0, 8'hFF);
        send_fields(OP_CHANNEL, 1'b0, 8'h7F, 1'b0, 1'b0, 8'h00);
        send_fields(OP_CHANNEL, 1'b0, 8'h7F, 1'b1, 1'b0, 8'h00);
    endtask

    // Meta and sysex headers and length fields.
    task automatic test_meta_sysex_events();
        // Wrong status on a buffer too short for the header: short header wins.
        send_fields(OP_META,  1'b1, 8'h90, 1'b1, 1'b0, 8'h00);
        // End of track, zero length.
        send_fields(OP_META,  1'b1, STATUS_META, 1'b0, 1'b0, 8'h00);
        send_fields(OP_META,  1'b0, 8'h2F, 1'b0, 1'b0, 8'h00);
        send_fields(OP_META,  1'b0, 8'h00, 1'b1, 1'b0, 8'h00);
        // Buffer ends inside the length field.
        send_fields(OP_SYSEX, 1'b1, STATUS_SYSEX, 1'b0, 1'b0, 8'h00);
        send_fields(OP_SYSEX, 1'b0, 8'h81, 1'b1, 1'b0, 8'h00);
        // Largest length, no payload behind it.
        send_fields(OP_META,  1'b1, STATUS_META, 1'b0, 1'b0, 8'h00);
        send_fields(OP_META,  1'b0, 8'h01, 1'b0, 1'b0, 8'h00);
        repeat (3) send_fields(OP_META, 1'b0, 8'hFF, 1'b0, 1'b0, 8'h00);
        send_fields(OP_META,  1'b0, 8'h7F, 1'b1, 1'b0, 8'h00);
        // Length field that never terminates.
        send_fields(OP_SYSEX, 1'b1, STATUS_SYSEX_ESC, 1'b0, 1'b0, 8'h00);
        repeat (4) send_fields(OP_SYSEX, 1'b0, 8'h80, 1'b0, 1'b0, 8'h00);
    endtask

    // One random event: mostly well formed with random content, the rest
    // broken, truncated, over-long or plain noise.
    task automatic send_random_event();
        logic [7:0]       status;
        logic [7:0]       running;
        logic [LEN_W-1:0] len;
        logic [1:0]       op;
        int               pick;
        int               shown;
        bit               mark_last;
        buffer_bytes.delete();
        running   = 8'($urandom);
        mark_last = ($urandom_range(19) != 0);
        pick      = $urandom_range(99);
        if (pick >= 95) begin
            repeat ($urandom_range(3, 1)) send_beat(noise_beat());
            return;
        end
        if (pick < 6) begin
            // Start beat on its own: empty buffers and the unused operation.
            send_fields(2'($urandom), 1'b1, 8'($urandom), 1'($urandom),
                        1'($urandom), running);
            beats_sent++;
            return;
        end
        if (pick < 50) begin
            op     = OP_CHANNEL;
            status = {1'b1, 3'($urandom_range(6)), 4'($urandom)};
            if ($urandom_range(3) == 0) begin
                // Running status: drop the status byte, now and then a bad one.
                running = ($urandom_range(9) == 0) ? 8'($urandom) : status;
            end else begin
                if ($urandom_range(19) == 0)
                    status = 8'($urandom);
                buffer_bytes.push_back(status);
            end
            repeat (int'(data_bytes_for(status)))
                buffer_bytes.push_back({$urandom_range(11) == 0, 7'($urandom)});
        end else begin
            op = (pick < 72) ? OP_META : OP_SYSEX;
            if (op == OP_META) begin
                buffer_bytes.push_back(($urandom_range(19) == 0) ? 8'($urandom) : STATUS_META);
                buffer_bytes.push_back(8'($urandom));
            end else begin
                if ($urandom_range(19) == 0)
                    buffer_bytes.push_back(8'($urandom));
                else
                    buffer_bytes.push_back($urandom_range(1) ? STATUS_SYSEX : STATUS_SYSEX_ESC);
            end
            pick = $urandom_range(99);
            len  = (pick < 70) ? LEN_W'($urandom_range(8)) :
                   (pick < 90) ? LEN_W'($urandom_range(40, 9)) : LEN_W'($urandom);
            if ($urandom_range(19) == 0)
                repeat ($urandom_range(5, 1)) buffer_bytes.push_back({1'b1, 7'($urandom)});
            else
                push_length(len);
            // Long payloads are cut short; the block only counts bytes.
            shown = (len > 40) ? int'($urandom_range(30)) : int'(len);
            repeat (shown) buffer_bytes.push_back(8'($urandom));
        end
        if ($urandom_range(9) == 0 && buffer_bytes.size() > 1)
            repeat ($urandom_range(buffer_bytes.size() - 1, 1)) void'(buffer_bytes.pop_back());
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(2, 1)) buffer_bytes.push_back(8'($urandom));
        send_buffer(op, running, mark_last);
    endtask

    // Random traffic with stretches free of idling and periodic drain pauses.
    task automatic test_random_traffic();
        int next_pause;
        next_pause = 250;
        beats_sent = 0;
        while (beats_sent < RANDOM_BEATS) begin
            quiet = (beats_sent % 300) >= 240;
            send_random_event();
            if (beats_sent >= next_pause) begin
                hold_until_drained();
                next_pause += 250;
            end
        end
        quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stray_and_empty();
        test_channel_events();
        test_meta_sysex_events();
        test_random_traffic();
        // Stop sending, let every owed verdict arrive, then idle so that the
        // two-stage pipeline can show any stray beat.
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin : run_limit
        #RUN_LIMIT_NS;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
